>>> src/tbe_pkg.sv
// tbe_pkg: shared constants, item types and helpers of the tape bytecode executor
// depends on: nothing
package tbe_pkg;

   // tape depth must be a power of two: pointer moves wrap by truncation
   localparam int TAPE_DEPTH  = 32768;
   localparam int PTR_W       = $clog2(TAPE_DEPTH);
   localparam int PC_W        = 16;
   localparam int OPCODE_W    = 4;
   localparam int OPERAND_W   = 16;
   localparam int BYTE_W      = 8;
   localparam int NEXT_PC_W   = 16;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef logic [PTR_W-1:0]     ptr_type;
   typedef logic [PC_W-1:0]      pc_type;
   typedef logic [BYTE_W-1:0]    byte_type;
   typedef logic [NEXT_PC_W-1:0] next_pc_type;

   // bytecode opcodes
   typedef enum logic [OPCODE_W-1:0] {
      OP_END     = 4'd0,
      OP_ADD     = 4'd1,
      OP_SUB     = 4'd2,
      OP_FWD     = 4'd3,
      OP_BACK    = 4'd4,
      OP_WRITE   = 4'd5,
      OP_READ    = 4'd6,
      OP_BZ      = 4'd7,
      OP_BNZ     = 4'd8
   } opcode_type;

   // work classes handed from the front to the back
   typedef enum logic [2:0] {
      CLS_NOP    = 3'd0,
      CLS_END    = 3'd1,
      CLS_ADD    = 3'd2,
      CLS_STORE  = 3'd3,
      CLS_WRITE  = 3'd4,
      CLS_BZ     = 3'd5,
      CLS_BNZ    = 3'd6,
      CLS_HALTED = 3'd7
   } cls_type;

   // one classified item: current cell address is already resolved
   typedef struct packed {
      cls_type  cls;
      ptr_type  cp;
      byte_type data;
      pc_type   target;
   } item_type;

   // program counter to the 16-bit result field
   function automatic next_pc_type pc_to_field(pc_type pc);
      logic [31:0] wide;
      wide = 32'(pc);
      return wide[NEXT_PC_W-1:0];
   endfunction

endpackage

>>> src/tbe_queue.sv
// tbe_queue: short item queue between the front and the back
// depends on: tbe_pkg
module tbe_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  tbe_pkg::item_type push_item,
   output logic              full,
   input  logic              pop,
   output logic              head_valid,
   output tbe_pkg::item_type head_item
);

   tbe_pkg::item_type                  slot_ff [tbe_pkg::QUEUE_DEPTH];
   logic [tbe_pkg::QPTR_W-1:0]         wr_ptr_ff, wr_ptr_in;
   logic [tbe_pkg::QPTR_W-1:0]         rd_ptr_ff, rd_ptr_in;
   logic [tbe_pkg::QCNT_W-1:0]         count_ff, count_in;

   assign full       = (count_ff == tbe_pkg::QCNT_W'(tbe_pkg::QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_item  = slot_ff[rd_ptr_ff];

   // pointer and count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == tbe_pkg::QPTR_W'(tbe_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == tbe_pkg::QPTR_W'(tbe_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // slot storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

>>> src/tbe_front.sv
// tbe_front: accepts request beats, tracks cell pointer and halt, classifies items
// depends on: tbe_pkg
module tbe_front (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [tbe_pkg::OPCODE_W-1:0]    req_opcode,
   input  logic [tbe_pkg::OPERAND_W-1:0]   req_operand,
   input  logic [tbe_pkg::BYTE_W-1:0]      req_in_byte,
   input  logic                            clearing,
   input  logic                            queue_full,
   output logic                            push,
   output tbe_pkg::item_type               push_item
);

   tbe_pkg::ptr_type cp_ff, cp_in;
   logic             halted_ff, halted_in;
   tbe_pkg::ptr_type step;

   assign req_ready = !queue_full && !clearing;
   assign push      = req_valid && req_ready;
   assign step      = tbe_pkg::ptr_type'(req_operand);

   // decode and pointer tracking
   always_comb begin
      cp_in            = cp_ff;
      halted_in        = halted_ff;
      push_item.cls    = tbe_pkg::CLS_NOP;
      push_item.cp     = cp_ff;
      push_item.data   = req_in_byte;
      push_item.target = tbe_pkg::pc_type'(req_operand);
      if (halted_ff) begin
         push_item.cls = tbe_pkg::CLS_HALTED;
      end else begin
         case (req_opcode)
            tbe_pkg::OP_END: begin
               push_item.cls = tbe_pkg::CLS_END;
               halted_in     = 1'b1;
            end
            tbe_pkg::OP_ADD: begin
               push_item.cls  = tbe_pkg::CLS_ADD;
               push_item.data = req_operand[tbe_pkg::BYTE_W-1:0];
            end
            tbe_pkg::OP_SUB: begin
               // subtract as add of the two's complement
               push_item.cls  = tbe_pkg::CLS_ADD;
               push_item.data = tbe_pkg::BYTE_W'(~req_operand[tbe_pkg::BYTE_W-1:0] + 1'b1);
            end
            tbe_pkg::OP_FWD: begin
               cp_in = cp_ff + step;
            end
            tbe_pkg::OP_BACK: begin
               cp_in = cp_ff - step;
            end
            tbe_pkg::OP_WRITE: begin
               push_item.cls = tbe_pkg::CLS_WRITE;
            end
            tbe_pkg::OP_READ: begin
               push_item.cls = tbe_pkg::CLS_STORE;
            end
            tbe_pkg::OP_BZ: begin
               push_item.cls = tbe_pkg::CLS_BZ;
            end
            tbe_pkg::OP_BNZ: begin
               push_item.cls = tbe_pkg::CLS_BNZ;
            end
            default: begin
               push_item.cls = tbe_pkg::CLS_NOP;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cp_ff     <= '0;
         halted_ff <= 1'b0;
      end else if (push) begin
         cp_ff     <= cp_in;
         halted_ff <= halted_in;
      end
   end

endmodule

>>> src/tbe_back.sv
// tbe_back: tape memory with clearing pass, cell read-modify-write, pc and result register
// depends on: tbe_pkg
module tbe_back (
   input  logic                             clock,
   input  logic                             reset,
   output logic                             clearing,
   input  logic                             head_valid,
   input  tbe_pkg::item_type                head_item,
   output logic                             pop,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [tbe_pkg::NEXT_PC_W-1:0]    rsp_next_pc,
   output logic [tbe_pkg::BYTE_W-1:0]       rsp_out_byte,
   output logic                             rsp_out_valid,
   output logic                             rsp_halted
);

   // tape memory
   tbe_pkg::byte_type tape [tbe_pkg::TAPE_DEPTH];

   logic              clearing_ff, clearing_in;
   tbe_pkg::ptr_type  clr_addr_ff, clr_addr_in;

   logic              exec_valid_ff, exec_valid_in;
   tbe_pkg::item_type exec_item_ff;
   tbe_pkg::byte_type rd_data_ff;
   logic              fwd_hit_ff;
   tbe_pkg::byte_type fwd_data_ff;

   tbe_pkg::pc_type   pc_ff, pc_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   tbe_pkg::next_pc_type          rsp_next_pc_ff;
   tbe_pkg::byte_type             rsp_out_byte_ff;
   logic                          rsp_out_valid_ff;
   logic                          rsp_halted_ff;

   logic              fire;
   tbe_pkg::byte_type cur_cell;
   logic              wr_en;
   tbe_pkg::byte_type wr_data;
   logic              mem_we;
   tbe_pkg::ptr_type  mem_wa;
   tbe_pkg::byte_type mem_wd;
   tbe_pkg::pc_type   pc_inc;
   tbe_pkg::byte_type out_byte;
   logic              out_valid;
   logic              out_halted;

   assign clearing      = clearing_ff;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_next_pc   = rsp_next_pc_ff;
   assign rsp_out_byte  = rsp_out_byte_ff;
   assign rsp_out_valid = rsp_out_valid_ff;
   assign rsp_halted    = rsp_halted_ff;

   // execute stage advances when the result register frees up
   assign fire = exec_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign pop  = head_valid && (!exec_valid_ff || fire);

   // current cell with forwarding of the write issued alongside its read
   assign cur_cell = fwd_hit_ff ? fwd_data_ff : rd_data_ff;
   assign pc_inc = pc_ff + 1'b1;

   // execute
   always_comb begin
      pc_in      = pc_inc;
      wr_en      = 1'b0;
      wr_data    = exec_item_ff.data;
      out_byte   = '0;
      out_valid  = 1'b0;
      out_halted = 1'b0;
      case (exec_item_ff.cls)
         tbe_pkg::CLS_END: begin
            pc_in      = pc_ff;
            out_halted = 1'b1;
         end
         tbe_pkg::CLS_HALTED: begin
            pc_in      = pc_ff;
            out_halted = 1'b1;
         end
         tbe_pkg::CLS_ADD: begin
            wr_en   = 1'b1;
            wr_data = cur_cell + exec_item_ff.data;
         end
         tbe_pkg::CLS_STORE: begin
            wr_en = 1'b1;
         end
         tbe_pkg::CLS_WRITE: begin
            out_byte  = cur_cell;
            out_valid = 1'b1;
         end
         tbe_pkg::CLS_BZ: begin
            if (cur_cell == '0) begin
               pc_in = exec_item_ff.target;
            end
         end
         tbe_pkg::CLS_BNZ: begin
            if (cur_cell != '0) begin
               pc_in = exec_item_ff.target;
            end
         end
         default: begin
            pc_in = pc_inc;
         end
      endcase
   end

   // memory write port shared by the clearing pass and the execute stage
   assign mem_we = clearing_ff || (fire && wr_en);
   assign mem_wa = clearing_ff ? clr_addr_ff : exec_item_ff.cp;
   assign mem_wd = clearing_ff ? '0 : wr_data;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         tape[mem_wa] <= mem_wd;
      end
      if (pop) begin
         rd_data_ff <= tape[head_item.cp];
      end
   end

   // clearing pass after reset
   always_comb begin
      clearing_in = clearing_ff;
      clr_addr_in = clr_addr_ff;
      if (clearing_ff) begin
         clr_addr_in = clr_addr_ff + 1'b1;
         if (clr_addr_ff == tbe_pkg::PTR_W'(tbe_pkg::TAPE_DEPTH - 1)) begin
            clearing_in = 1'b0;
         end
      end
   end

   // control next state
   always_comb begin
      exec_valid_in = exec_valid_ff;
      rsp_valid_in  = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (fire) begin
         rsp_valid_in  = 1'b1;
         exec_valid_in = 1'b0;
      end
      if (pop) begin
         exec_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff   <= 1'b1;
         clr_addr_ff   <= '0;
         exec_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         pc_ff         <= '0;
      end else begin
         clearing_ff   <= clearing_in;
         clr_addr_ff   <= clr_addr_in;
         exec_valid_ff <= exec_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (fire) begin
            pc_ff <= pc_in;
         end
      end
   end

   // execute stage payload and forwarding capture
   always_ff @(posedge clock) begin
      if (pop) begin
         exec_item_ff <= head_item;
         fwd_hit_ff   <= fire && wr_en && (exec_item_ff.cp == head_item.cp);
         fwd_data_ff  <= wr_data;
      end
   end

   // result beat payload
   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_next_pc_ff   <= tbe_pkg::pc_to_field(pc_in);
         rsp_out_byte_ff  <= out_byte;
         rsp_out_valid_ff <= out_valid;
         rsp_halted_ff    <= out_halted;
      end
   end

endmodule

>>> src/tape_bytecode_executor.sv
// tape_bytecode_executor: requests pass the queue, execute and result registers.
// throughput one instruction per cycle while rsp_ready is high; the tape memory read is
// issued from the queue head and a write made in the same cycle is forwarded to the
// next item. reset (synchronous) clears pointer, pc and halt, then a clearing pass
// writes zero to all TAPE_DEPTH cells, one a cycle, with req_ready held low.
// depends on: tbe_pkg, tbe_front, tbe_queue, tbe_back
module tape_bytecode_executor (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [tbe_pkg::OPCODE_W-1:0]    req_opcode,
   input  logic [tbe_pkg::OPERAND_W-1:0]   req_operand,
   input  logic [tbe_pkg::BYTE_W-1:0]      req_in_byte,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [tbe_pkg::NEXT_PC_W-1:0]   rsp_next_pc,
   output logic [tbe_pkg::BYTE_W-1:0]      rsp_out_byte,
   output logic                            rsp_out_valid,
   output logic                            rsp_halted
);

   logic              clearing;
   logic              queue_full;
   logic              push;
   tbe_pkg::item_type push_item;
   logic              pop;
   logic              head_valid;
   tbe_pkg::item_type head_item;

   // front: accept and classify
   tbe_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_opcode  (req_opcode),
      .req_operand (req_operand),
      .req_in_byte (req_in_byte),
      .clearing    (clearing),
      .queue_full  (queue_full),
      .push        (push),
      .push_item   (push_item)
   );

   // decoupling queue
   tbe_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_item  (push_item),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_item  (head_item)
   );

   // back: tape access and execution
   tbe_back u_back (
      .clock         (clock),
      .reset         (reset),
      .clearing      (clearing),
      .head_valid    (head_valid),
      .head_item     (head_item),
      .pop           (pop),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_next_pc   (rsp_next_pc),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_out_valid (rsp_out_valid),
      .rsp_halted    (rsp_halted)
   );

endmodule
